// ===== design/serial_duty_entry_pwm_assert.svh =====
// ----------------------------------------------------------------------------
// serial_duty_entry_pwm_assert.svh
// Concurrent assertion macros for the serial duty entry PWM block.
// ----------------------------------------------------------------------------
`ifndef SERIAL_DUTY_ENTRY_PWM_ASSERT_SVH
`define SERIAL_DUTY_ENTRY_PWM_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SDEP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdep assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define SDEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdep assertion failed: next-cycle implication");

`endif

// ===== design/sdep_pkg.sv =====
// ----------------------------------------------------------------------------
// sdep_pkg
// Shared types, codes and constants of the serial duty entry PWM block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdep_pkg;

    localparam int MENU_W = 2;
    localparam int DUTY_W = 7;
    localparam int BYTE_W = 8;
    localparam int SUM_W  = 16;

    localparam int PERIOD_TOP_DEFAULT = 100;

    localparam logic [MENU_W-1:0] MENU_MAIN = 2'd0;
    localparam logic [MENU_W-1:0] MENU_DUTY = 2'd1;
    localparam logic [MENU_W-1:0] MENU_FREQ = 2'd2;

    localparam logic [BYTE_W-1:0] KEY_ENTER  = 8'd13;
    localparam logic [BYTE_W-1:0] KEY_CANCEL = 8'h63;
    localparam logic [BYTE_W-1:0] KEY_DUTY   = 8'h64;
    localparam logic [BYTE_W-1:0] KEY_FREQ   = 8'h66;

    localparam logic signed [SUM_W-1:0] DIGIT_ZERO   = 16'sd48;
    localparam logic signed [SUM_W-1:0] WEIGHT_TEN   = 16'sd10;
    localparam logic signed [SUM_W-1:0] WEIGHT_HUND  = 16'sd100;
    localparam logic signed [SUM_W-1:0] SUM_DUTY_MAX = 16'sd100;

    localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;
    localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd100;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              committed;
        logic [MENU_W-1:0] menu;
    } entry_res_t;

endpackage

// ===== design/sdep_entry.sv =====
// ----------------------------------------------------------------------------
// sdep_entry
// Menu state, digit buffer and committed duty value; serial byte handling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdep_entry (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  logic [sdep_pkg::BYTE_W-1:0]  rx_byte,
    output logic [sdep_pkg::DUTY_W-1:0]  duty,
    output sdep_pkg::entry_res_t         res
);

    logic [sdep_pkg::MENU_W-1:0] menu_reg, menu_next;
    logic [sdep_pkg::BYTE_W-1:0] buf0_reg, buf0_next;
    logic [sdep_pkg::BYTE_W-1:0] buf1_reg, buf1_next;
    logic [1:0]                  fill_reg, fill_next;
    logic [sdep_pkg::DUTY_W-1:0] duty_reg, duty_next;
    logic                        commit;
    logic signed [sdep_pkg::SUM_W-1:0] d0, d1, d2, sum;

    function automatic logic signed [sdep_pkg::SUM_W-1:0] digit_of(
        input logic [sdep_pkg::BYTE_W-1:0] b);
        return $signed({{(sdep_pkg::SUM_W-sdep_pkg::BYTE_W){1'b0}}, b})
            - sdep_pkg::DIGIT_ZERO;
    endfunction

    assign d0 = digit_of(buf0_reg);
    assign d1 = digit_of(buf1_reg);
    assign d2 = digit_of(rx_byte);

    always_comb
    begin
        menu_next = menu_reg;
        buf0_next = buf0_reg;
        buf1_next = buf1_reg;
        fill_next = fill_reg;
        duty_next = duty_reg;
        commit    = 1'b0;
        sum       = '0;
        case (menu_reg)
            sdep_pkg::MENU_DUTY:
            begin
                if (rx_byte == sdep_pkg::KEY_CANCEL)
                begin
                    menu_next = sdep_pkg::MENU_MAIN;
                end
                else if (rx_byte == sdep_pkg::KEY_ENTER)
                begin
                    commit = 1'b1;
                    if (fill_reg == 2'd1)
                        sum = d0;
                    else if (fill_reg == 2'd2)
                        sum = d0 * sdep_pkg::WEIGHT_TEN + d1;
                end
                else if (fill_reg == 2'd0)
                begin
                    buf0_next = rx_byte;
                    fill_next = 2'd1;
                end
                else if (fill_reg == 2'd1)
                begin
                    buf1_next = rx_byte;
                    fill_next = 2'd2;
                end
                else
                begin
                    commit = 1'b1;
                    sum = d0 * sdep_pkg::WEIGHT_HUND + d1 * sdep_pkg::WEIGHT_TEN + d2;
                end
            end
            sdep_pkg::MENU_FREQ:
            begin
                if (rx_byte == sdep_pkg::KEY_CANCEL || rx_byte == sdep_pkg::KEY_ENTER)
                    menu_next = sdep_pkg::MENU_MAIN;
            end
            default:
            begin
                if (rx_byte == sdep_pkg::KEY_DUTY)
                    menu_next = sdep_pkg::MENU_DUTY;
                else if (rx_byte == sdep_pkg::KEY_FREQ)
                    menu_next = sdep_pkg::MENU_FREQ;
            end
        endcase
        if (commit)
        begin
            if (sum < 0)
                duty_next = '0;
            else if (sum > sdep_pkg::SUM_DUTY_MAX)
                duty_next = sdep_pkg::DUTY_MAX;
            else
                duty_next = sum[sdep_pkg::DUTY_W-1:0];
            buf0_next = '0;
            buf1_next = '0;
            fill_next = 2'd0;
            menu_next = sdep_pkg::MENU_MAIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            menu_reg <= sdep_pkg::MENU_MAIN;
            buf0_reg <= '0;
            buf1_reg <= '0;
            fill_reg <= 2'd0;
            duty_reg <= sdep_pkg::DUTY_RESET;
        end
        else if (take)
        begin
            menu_reg <= menu_next;
            buf0_reg <= buf0_next;
            buf1_reg <= buf1_next;
            fill_reg <= fill_next;
            duty_reg <= duty_next;
        end
    end

    // a tick leaves the menu and the duty untouched
    assign duty          = duty_reg;
    assign res.duty      = take ? duty_next : duty_reg;
    assign res.committed = commit & take;
    assign res.menu      = take ? menu_next : menu_reg;

endmodule

// ===== design/sdep_pwm.sv =====
// ----------------------------------------------------------------------------
// sdep_pwm
// Tick counter over 0..PERIOD_TOP and LED state against the duty value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdep_pwm #(
    parameter int PERIOD_TOP = sdep_pkg::PERIOD_TOP_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tick,
    input  logic [sdep_pkg::DUTY_W-1:0] duty,
    output logic                        led_next
);

    localparam int CNT_W = $clog2(PERIOD_TOP + 1);
    localparam int CMP_W = (CNT_W > sdep_pkg::DUTY_W) ? CNT_W : sdep_pkg::DUTY_W;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             led_reg;
    logic [CMP_W-1:0] cnt_ext, duty_ext;

    assign cnt_ext  = CMP_W'(cnt_reg);
    assign duty_ext = CMP_W'(duty);

    always_comb
    begin
        led_next = led_reg;
        cnt_next = cnt_reg;
        if (tick)
        begin
            if (cnt_ext < duty_ext)
                led_next = 1'b1;
            else if (cnt_ext > duty_ext)
                led_next = 1'b0;
            if (cnt_reg >= CNT_W'(PERIOD_TOP))
                cnt_next = '0;
            else
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            led_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            led_reg <= led_next;
        end
    end

endmodule

// ===== design/serial_duty_entry_pwm.sv =====
// ----------------------------------------------------------------------------
// serial_duty_entry_pwm
// Serial duty-cycle entry menu driving a tick-based PWM LED.
//
// Input channel: in_valid/in_stall with mode (0 serial byte, 1 timer tick)
// and rx_byte. Output channel: out_valid/out_stall with led_on,
// duty_percent, duty_committed and menu_now; one result per input
// transaction.
// A transaction is captured in the input register, evaluated by the entry
// and PWM logic, and written to the result register, which drives
// out_valid; a receiver stall can hold it in the input register first.
// Throughput is one transaction per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds; the input register
// holds one more transaction, and only then is in_stall raised.
// Reset: main menu, empty digit buffer, duty 100, counter 0, LED off,
// both registers empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_duty_entry_pwm_assert.svh"

module serial_duty_entry_pwm #(
    parameter int PERIOD_TOP = sdep_pkg::PERIOD_TOP_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic [sdep_pkg::BYTE_W-1:0] rx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        led_on,
    output logic [sdep_pkg::DUTY_W-1:0] duty_percent,
    output logic                        duty_committed,
    output logic [sdep_pkg::MENU_W-1:0] menu_now
);

    logic                        s1_valid_reg;
    logic                        s1_mode_reg;
    logic [sdep_pkg::BYTE_W-1:0] s1_byte_reg;
    logic                        out_valid_reg;
    logic                        led_reg;
    logic [sdep_pkg::DUTY_W-1:0] duty_reg;
    logic                        committed_reg;
    logic [sdep_pkg::MENU_W-1:0] menu_reg;

    logic                        advance_ok;
    logic                        load;
    logic                        fire;
    logic                        led_next;
    logic [sdep_pkg::DUTY_W-1:0] duty_cur;
    sdep_pkg::entry_res_t        step_res;

    assign advance_ok = !out_valid_reg || !out_stall;
    assign fire       = s1_valid_reg && advance_ok;
    assign in_stall   = s1_valid_reg && !advance_ok;
    assign load       = in_valid && !in_stall;

    sdep_entry u_entry (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (fire && !s1_mode_reg),
        .rx_byte (s1_byte_reg),
        .duty    (duty_cur),
        .res     (step_res)
    );

    sdep_pwm #(
        .PERIOD_TOP (PERIOD_TOP)
    ) u_pwm (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (fire && s1_mode_reg),
        .duty     (duty_cur),
        .led_next (led_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                s1_valid_reg <= 1'b1;
            else if (fire)
                s1_valid_reg <= 1'b0;
            if (advance_ok)
                out_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_mode_reg <= mode;
            s1_byte_reg <= rx_byte;
        end
        if (fire)
        begin
            led_reg       <= led_next;
            duty_reg      <= step_res.duty;
            committed_reg <= step_res.committed;
            menu_reg      <= step_res.menu;
        end
    end

    assign out_valid      = out_valid_reg;
    assign led_on         = led_reg;
    assign duty_percent   = duty_reg;
    assign duty_committed = committed_reg;
    assign menu_now       = menu_reg;

    `SDEP_ASSERT_IMPLY(a_commit_main, clk, rst_n, out_valid_reg && committed_reg, menu_reg == sdep_pkg::MENU_MAIN)
    `SDEP_ASSERT_IMPLY(a_duty_range, clk, rst_n, out_valid_reg, duty_reg <= sdep_pkg::DUTY_MAX)
    `SDEP_ASSERT_NEXT(a_fire_to_out, clk, rst_n, fire, out_valid_reg)
    `SDEP_ASSERT_IMPLY(a_tick_no_commit, clk, rst_n, fire && s1_mode_reg, !step_res.committed)

endmodule

// ===== tb/serial_duty_entry_pwm_tb.sv =====
// ----------------------------------------------------------------------------
// serial_duty_entry_pwm_tb
// Self-checking bench for the serial duty entry PWM block. A short table
// covers reset values, the menu keys, empty and three-digit commits,
// saturation at both ends and leaving duty entry with its digits kept.
// Random traffic follows: timer tick bursts, well-formed duty and
// frequency entry sequences and noise bytes. Both sides idle in short
// random bursts. Every result is checked in order against its table row, or else
// a bit-accurate model of the menu, the digit buffer and the PWM counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_duty_entry_pwm_tb;

    localparam int RANDOM_ITEMS   = 950;
    localparam int QUIET_ITEMS    = 100;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PERIOD_TOP     = sdep_pkg::PERIOD_TOP_DEFAULT;

    localparam logic [sdep_pkg::BYTE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [sdep_pkg::BYTE_W-1:0] CHAR_X    = 8'h78;
    localparam logic                        TICK      = 1'b1;
    localparam logic                        SERIAL    = 1'b0;

    typedef struct packed {
        logic                        led;
        logic [sdep_pkg::DUTY_W-1:0] duty;
        logic                        committed;
        logic [sdep_pkg::MENU_W-1:0] menu;
    } pwm_result_t;

    typedef struct packed {
        logic                        mode;
        logic [sdep_pkg::BYTE_W-1:0] data;
        logic                        typed;
        pwm_result_t                 result;
    } stim_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic                        mode;
    logic [sdep_pkg::BYTE_W-1:0] rx_byte;
    logic                        out_valid;
    logic                        out_stall;
    logic                        led_on;
    logic [sdep_pkg::DUTY_W-1:0] duty_percent;
    logic                        duty_committed;
    logic [sdep_pkg::MENU_W-1:0] menu_now;

    // expectation attached to the transaction being driven
    logic        row_typed;
    pwm_result_t row_result;

    // model state
    logic [sdep_pkg::MENU_W-1:0] menu_level = sdep_pkg::MENU_MAIN;
    logic [sdep_pkg::BYTE_W-1:0] digit_buf [0:1];
    int                          digit_fill = 0;
    logic [sdep_pkg::DUTY_W-1:0] duty_level = sdep_pkg::DUTY_RESET;
    int                          tick_count = 0;
    logic                        led_lit = 1'b0;

    pwm_result_t expected_results [$];
    stim_row_t   directed_rows [$];

    int  errors = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  commits_seen = 0;
    int  ticks_seen = 0;
    int  cycles_idle = 0;
    int  stall_left = 0;
    bit  quiet = 1'b0;

    serial_duty_entry_pwm u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .led_on         (led_on),
        .duty_percent   (duty_percent),
        .duty_committed (duty_committed),
        .menu_now       (menu_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int digit_value(input logic [sdep_pkg::BYTE_W-1:0] b);
        return int'(b) - int'(sdep_pkg::DIGIT_ZERO);
    endfunction

    function automatic logic [sdep_pkg::BYTE_W-1:0] digit_char(input int n);
        return CHAR_ZERO + sdep_pkg::BYTE_W'(n);
    endfunction

    function automatic void commit_duty(input int sum);
        if (sum < 0)
            duty_level = '0;
        else if (sum > int'(sdep_pkg::SUM_DUTY_MAX))
            duty_level = sdep_pkg::DUTY_MAX;
        else
            duty_level = sdep_pkg::DUTY_W'(sum);
        digit_buf[0] = '0;
        digit_buf[1] = '0;
        digit_fill = 0;
        menu_level = sdep_pkg::MENU_MAIN;
    endfunction

    function automatic pwm_result_t apply_transaction(
        input logic m, input logic [sdep_pkg::BYTE_W-1:0] b);
        int          sum;
        pwm_result_t r;
        r.committed = 1'b0;
        if (m)
        begin
            if (tick_count < duty_level)
                led_lit = 1'b1;
            else if (tick_count > duty_level)
                led_lit = 1'b0;
            tick_count = (tick_count >= PERIOD_TOP) ? 0 : tick_count + 1;
        end
        else if (menu_level == sdep_pkg::MENU_DUTY)
        begin
            if (b == sdep_pkg::KEY_CANCEL)
                menu_level = sdep_pkg::MENU_MAIN;
            else if (b == sdep_pkg::KEY_ENTER)
            begin
                sum = 0;
                if (digit_fill == 1)
                    sum = digit_value(digit_buf[0]);
                else if (digit_fill >= 2)
                    sum = digit_value(digit_buf[0]) * int'(sdep_pkg::WEIGHT_TEN)
                        + digit_value(digit_buf[1]);
                commit_duty(sum);
                r.committed = 1'b1;
            end
            else if (digit_fill < 2)
            begin
                digit_buf[digit_fill] = b;
                digit_fill++;
            end
            else
            begin
                sum = digit_value(digit_buf[0]) * int'(sdep_pkg::WEIGHT_HUND)
                    + digit_value(digit_buf[1]) * int'(sdep_pkg::WEIGHT_TEN)
                    + digit_value(b);
                commit_duty(sum);
                r.committed = 1'b1;
            end
        end
        else if (menu_level == sdep_pkg::MENU_FREQ)
        begin
            if (b == sdep_pkg::KEY_CANCEL || b == sdep_pkg::KEY_ENTER)
                menu_level = sdep_pkg::MENU_MAIN;
        end
        else
        begin
            if (b == sdep_pkg::KEY_DUTY)
                menu_level = sdep_pkg::MENU_DUTY;
            else if (b == sdep_pkg::KEY_FREQ)
                menu_level = sdep_pkg::MENU_FREQ;
        end
        r.led = led_lit;
        r.duty = duty_level;
        r.menu = menu_level;
        return r;
    endfunction

    function automatic stim_row_t plain(input logic m,
                                       input logic [sdep_pkg::BYTE_W-1:0] b);
        stim_row_t s;
        s = '0;
        s.mode = m;
        s.data = b;
        return s;
    endfunction

    function automatic stim_row_t checked(input logic m,
                                          input logic [sdep_pkg::BYTE_W-1:0] b,
                                          input logic led, input int duty,
                                          input logic com,
                                          input logic [sdep_pkg::MENU_W-1:0] menu);
        stim_row_t s;
        s.mode = m;
        s.data = b;
        s.typed = 1'b1;
        s.result.led = led;
        s.result.duty = sdep_pkg::DUTY_W'(duty);
        s.result.committed = com;
        s.result.menu = menu;
        return s;
    endfunction

    task automatic send_item(input stim_row_t s);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= s.mode;
        rx_byte <= s.data;
        row_typed <= s.typed;
        row_result <= s.result;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_random(input logic m);
        send_item(plain(m, sdep_pkg::BYTE_W'($urandom_range(0, 255))));
    endtask

    task automatic duty_sequence();
        int n;
        logic [sdep_pkg::BYTE_W-1:0] b;
        send_item(plain(SERIAL, sdep_pkg::KEY_DUTY));
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                b = sdep_pkg::BYTE_W'($urandom_range(0, 255));
            else if (i == 0 && n == 3)
                b = digit_char($urandom_range(0, 1));
            else
                b = digit_char($urandom_range(0, 9));
            send_item(plain(SERIAL, b));
            if ($urandom_range(0, 5) == 0)
                send_random(TICK);
        end
        if (n < 3)
        begin
            case ($urandom_range(0, 5))
                0: send_item(plain(SERIAL, sdep_pkg::KEY_CANCEL));
                1: ;
                default: send_item(plain(SERIAL, sdep_pkg::KEY_ENTER));
            endcase
        end
    endtask

    task automatic freq_sequence();
        send_item(plain(SERIAL, sdep_pkg::KEY_FREQ));
        repeat ($urandom_range(0, 3))
            send_random(SERIAL);
        send_item(plain(SERIAL, $urandom_range(0, 1) ? sdep_pkg::KEY_CANCEL
                                                     : sdep_pkg::KEY_ENTER));
    endtask

    // receiver stall bursts
    always @(negedge clk)
    begin
        if (!rst_n || quiet)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : monitor
        pwm_result_t pred;
        pwm_result_t seen;
        pwm_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                pred = apply_transaction(mode, rx_byte);
                want = row_typed ? row_result : pred;
                expected_results.push_back(want);
                if (want.committed)
                    commits_seen++;
                if (mode)
                    ticks_seen++;
            end
            if (out_valid && !out_stall)
            begin
                seen.led = led_on;
                seen.duty = duty_percent;
                seen.committed = duty_committed;
                seen.menu = menu_now;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result led=%0d duty=%0d committed=%0d menu=%0d",
                             $time, seen.led, seen.duty, seen.committed, seen.menu);
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (seen !== want)
                    begin
                        errors++;
                        $display({"%0t: mismatch: expected led=%0d duty=%0d committed=%0d ",
                                  "menu=%0d, actual led=%0d duty=%0d committed=%0d menu=%0d"},
                                 $time, want.led, want.duty, want.committed, want.menu,
                                 seen.led, seen.duty, seen.committed, seen.menu);
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                cycles_idle = 0;
            else
                cycles_idle++;
        end
    end

    initial
    begin
        wait (cycles_idle >= WATCHDOG_LIMIT);
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int total;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = 1'b0;
        rx_byte = '0;
        out_stall = 1'b0;
        row_typed = 1'b0;
        row_result = '0;
        digit_buf[0] = '0;
        digit_buf[1] = '0;

        // reset values, empty enter, three-digit commit, low saturation
        directed_rows.push_back(checked(TICK, 8'h00, 1'b1, 100, 1'b0, sdep_pkg::MENU_MAIN));
        directed_rows.push_back(checked(SERIAL, CHAR_X, 1'b1, 100, 1'b0, sdep_pkg::MENU_MAIN));
        directed_rows.push_back(checked(SERIAL, sdep_pkg::KEY_DUTY, 1'b1, 100, 1'b0,
                                        sdep_pkg::MENU_DUTY));
        directed_rows.push_back(checked(SERIAL, sdep_pkg::KEY_ENTER, 1'b1, 0, 1'b1,
                                        sdep_pkg::MENU_MAIN));
        directed_rows.push_back(plain(TICK, 8'hFF));
        directed_rows.push_back(plain(SERIAL, sdep_pkg::KEY_DUTY));
        directed_rows.push_back(plain(SERIAL, digit_char(1)));
        directed_rows.push_back(plain(SERIAL, digit_char(0)));
        directed_rows.push_back(checked(SERIAL, digit_char(0), 1'b0, 100, 1'b1,
                                        sdep_pkg::MENU_MAIN));
        directed_rows.push_back(plain(SERIAL, sdep_pkg::KEY_DUTY));
        directed_rows.push_back(plain(SERIAL, 8'h00));
        directed_rows.push_back(plain(SERIAL, 8'h00));
        directed_rows.push_back(checked(SERIAL, 8'h00, 1'b0, 0, 1'b1, sdep_pkg::MENU_MAIN));
        directed_rows.push_back(plain(SERIAL, sdep_pkg::KEY_DUTY));
        directed_rows.push_back(plain(SERIAL, digit_char(4)));
        directed_rows.push_back(plain(SERIAL, digit_char(2)));
        directed_rows.push_back(plain(SERIAL, sdep_pkg::KEY_ENTER));
        // cancel keeps the buffered digit for the next entry
        directed_rows.push_back(plain(SERIAL, sdep_pkg::KEY_DUTY));
        directed_rows.push_back(plain(SERIAL, digit_char(7)));
        directed_rows.push_back(plain(SERIAL, sdep_pkg::KEY_CANCEL));
        directed_rows.push_back(plain(SERIAL, sdep_pkg::KEY_DUTY));
        directed_rows.push_back(plain(SERIAL, sdep_pkg::KEY_ENTER));
        directed_rows.push_back(plain(SERIAL, sdep_pkg::KEY_FREQ));
        directed_rows.push_back(plain(SERIAL, sdep_pkg::KEY_DUTY));
        directed_rows.push_back(plain(SERIAL, sdep_pkg::KEY_CANCEL));
        directed_rows.push_back(plain(SERIAL, sdep_pkg::KEY_FREQ));
        directed_rows.push_back(plain(SERIAL, sdep_pkg::KEY_ENTER));
        // non-digit bytes count as byte minus '0'
        directed_rows.push_back(plain(SERIAL, sdep_pkg::KEY_DUTY));
        directed_rows.push_back(plain(SERIAL, 8'hFF));
        directed_rows.push_back(plain(SERIAL, 8'hFF));
        directed_rows.push_back(plain(SERIAL, sdep_pkg::KEY_ENTER));

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        total = items_sent + RANDOM_ITEMS;
        while (items_sent < total)
        begin
            quiet = (items_sent > total - QUIET_ITEMS);
            case ($urandom_range(0, 9))
                0, 1, 2: repeat ($urandom_range(1, 40)) send_random(TICK);
                3, 4, 5, 6: duty_sequence();
                7: freq_sequence();
                default: send_random(1'($urandom_range(0, 1)));
            endcase
        end
        quiet = 1'b1;
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d transactions sent, %0d results checked", items_sent, results_checked);
        $display("%0d timer ticks, %0d duty commits", ticks_seen, commits_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
